// File: rtl/heightmap_grid_vertex_normals_assert.svh
// Assertion macros used by the sequencer of the height-map vertex unit.
`ifndef HEIGHTMAP_GRID_VERTEX_NORMALS_ASSERT_SVH
`define HEIGHTMAP_GRID_VERTEX_NORMALS_ASSERT_SVH

// Same-cycle implication, checked on clk, quiet during rst.
`define HGVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet during rst.
`define HGVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hgvn_pkg.sv
// Shared types and constants of the height-map vertex unit.
`timescale 1ns / 1ps
package hgvn_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int ADDR_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int STORE_DEPTH = 65536;
  localparam int DIV_W      = 32;
  localparam int DIVISOR_W  = 16;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_HEIGHTS  = 3'd4;

  typedef enum logic [1:0] {
    DIV_SRC_ADDR,
    DIV_SRC_X,
    DIV_SRC_Y,
    DIV_SRC_Z
  } div_src_t;

  typedef struct packed {
    logic       store_wr;
    logic       latch_in;
    logic       div_start;
    div_src_t   div_src;
    logic       latch_cr;
    logic       acc_clr;
    logic [2:0] rd_sel;
    logic       acc_en;
    logic [2:0] acc_sel;
    logic       mul_en;
    logic       flat_norm;
    logic       load_x;
    logic       load_y;
    logic       load_z;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_of_grid;
    logic n_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/hgvn_if.sv
// Valid/ready channel interfaces for vertex requests and vertex results.
`timescale 1ns / 1ps
interface hgvn_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] vertex_addr;
  logic [15:0] height_sample;

  modport source (output valid, cmd, vertex_addr, height_sample, input ready);
  modport sink   (input valid, cmd, vertex_addr, height_sample, output ready);
endinterface

interface hgvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_y;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic signed [31:0] norm_z;

  modport source (output valid, pos_y, norm_x, norm_y, norm_z, input ready);
  modport sink   (input valid, pos_y, norm_x, norm_y, norm_z, output ready);
endinterface

// File: rtl/hgvn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hgvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hgvn_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hgvn_div #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [D-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     dvs;
  logic [D:0]       rem_shift;
  logic             fits;

  assign rem_shift = {remainder, quotient[W-1]};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= CNT_W'(W);
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[W-2:0], fits};
      remainder <= fits ? D'(rem_shift - {1'b0, dvs}) : rem_shift[D-1:0];
      cnt       <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// File: rtl/hgvn_ctrl.sv
// Sequencer of the vertex unit: store, locate, fetch, scale, divide, deliver.
`timescale 1ns / 1ps
`include "heightmap_grid_vertex_normals_assert.svh"
module hgvn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  hgvn_pkg::dp_stat_t stat,
  output hgvn_pkg::ctl_cmd_t cmd
);
  import hgvn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_ADDR,
    S_CHECK,
    S_FETCH,
    S_SCALE,
    S_PREP,
    S_DIV_X,
    S_DIV_Y,
    S_DIV_Z,
    S_FINISH
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'd7;

  state_t     state, state_next;
  logic [2:0] step;

  always_comb begin
    cmd        = '0;
    cmd.div_src = DIV_SRC_ADDR;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        // hold off transfers while reset is applied
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_cmd == CMD_STORE) begin
            cmd.store_wr = 1'b1;
          end else begin
            cmd.latch_in  = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_DIV_ADDR;
          end
        end
      end
      S_DIV_ADDR: begin
        if (stat.div_done) begin
          cmd.latch_cr = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.acc_clr = 1'b1;
        state_next  = stat.out_of_grid ? S_IDLE : S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_sel  = step;
        cmd.acc_en  = step != 3'd0;
        cmd.acc_sel = step - 3'd1;
        if (step == LAST_STEP) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.mul_en = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        if (stat.n_zero) begin
          cmd.flat_norm = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_SRC_X;
          state_next    = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (stat.div_done) begin
          cmd.load_x    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_SRC_Y;
          state_next    = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (stat.div_done) begin
          cmd.load_y    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_SRC_Z;
          state_next    = S_DIV_Z;
        end
      end
      S_DIV_Z: begin
        if (stat.div_done) begin
          cmd.load_z = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_FETCH) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
    end
  end

  `HGVN_ASSERT_NOW(a_div_start_idle, cmd.div_start, !stat.div_busy, "divider restarted while busy")
  `HGVN_ASSERT_NOW(a_load_free, cmd.out_load, !stat.out_busy, "result overwritten before transfer")
  `HGVN_ASSERT_NOW(a_done_expected, stat.div_done, (state == S_DIV_ADDR || state == S_DIV_X || state == S_DIV_Y || state == S_DIV_Z), "quotient arrived outside a divide state")

endmodule

// File: rtl/hgvn_dp.sv
// Datapath: config registers, height store, neighbor sums, divider, result register.
`timescale 1ns / 1ps
module hgvn_dp #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hgvn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hgvn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [15:0]                       in_addr,
  input  logic [15:0]                       in_sample,
  input  hgvn_pkg::ctl_cmd_t                cmd,
  output hgvn_pkg::dp_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [31:0]                pos_y,
  output logic signed [31:0]                norm_x,
  output logic signed [31:0]                norm_y,
  output logic signed [31:0]                norm_z
);
  import hgvn_pkg::*;

  localparam logic [2:0] NB_C  = 3'd0;
  localparam logic [2:0] NB_L  = 3'd1;
  localparam logic [2:0] NB_R  = 3'd2;
  localparam logic [2:0] NB_U  = 3'd3;
  localparam logic [2:0] NB_D  = 3'd4;
  localparam logic [2:0] NB_UR = 3'd5;
  localparam logic [2:0] NB_DL = 3'd6;

  function automatic logic signed [2:0] coef_x(logic [2:0] nb, logic [3:0] q);
    logic [2:0] v;
    v = 3'd0;
    case (nb)
      NB_C:    v = 3'(q[1]) + 3'(q[3]) - 3'(q[0]) - 3'(q[2]);
      NB_L:    v = 3'(q[0]) + 3'(q[2]);
      NB_R:    v = 3'd0 - 3'(q[1]) - 3'(q[3]);
      NB_U:    v = 3'(q[1]);
      NB_D:    v = 3'd0 - 3'(q[2]);
      NB_UR:   v = 3'd0 - 3'(q[1]);
      NB_DL:   v = 3'(q[2]);
      default: v = 3'd0;
    endcase
    return $signed(v);
  endfunction

  function automatic logic signed [2:0] coef_z(logic [2:0] nb, logic [3:0] q);
    logic [2:0] v;
    v = 3'd0;
    case (nb)
      NB_C:    v = 3'(q[2]) + 3'(q[3]) - 3'(q[0]) - 3'(q[1]);
      NB_U:    v = 3'(q[0]) + 3'(q[1]);
      NB_UR:   v = 3'(q[1]);
      NB_R:    v = 3'd0 - 3'(q[1]);
      NB_L:    v = 3'(q[2]);
      NB_DL:   v = 3'd0 - 3'(q[2]);
      NB_D:    v = 3'd0 - 3'(q[2]) - 3'(q[3]);
      default: v = 3'd0;
    endcase
    return $signed(v);
  endfunction

  // config registers
  logic [8:0]         cols_reg, rows_reg;
  logic [7:0]         scale_reg;
  logic signed [10:0] base_reg;
  logic               use_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg  <= 9'd256;
      rows_reg  <= 9'd256;
      scale_reg <= 8'd80;
      base_reg  <= -11'sd80;
      use_reg   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COLS:    cols_reg  <= cfg_data[8:0];
        CFG_GRID_ROWS:    rows_reg  <= cfg_data[8:0];
        CFG_HEIGHT_SCALE: scale_reg <= cfg_data[7:0];
        CFG_BASE_HEIGHT:  base_reg  <= $signed(cfg_data);
        CFG_USE_HEIGHTS:  use_reg   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [8:0] cols_eff, rows_eff;

  always_comb begin
    if (cols_reg == 9'd0) begin
      cols_eff = 9'd1;
    end else if (13'(cols_reg) > 13'(MAX_COLS)) begin
      cols_eff = 9'(MAX_COLS);
    end else begin
      cols_eff = cols_reg;
    end
    if (rows_reg == 9'd0) begin
      rows_eff = 9'd1;
    end else if (13'(rows_reg) > 13'(MAX_ROWS)) begin
      rows_eff = 9'(MAX_ROWS);
    end else begin
      rows_eff = rows_reg;
    end
  end

  // vertex location and touching quads
  logic [15:0] addr_r;
  logic [8:0]  c_r;
  logic [15:0] r_r;
  logic [3:0]  q;
  logic [2:0]  n;
  logic        c_lo, c_hi, r_lo, r_hi;

  assign c_lo = c_r != 9'd0;
  assign c_hi = ({1'b0, c_r} + 10'd1) < {1'b0, cols_eff};
  assign r_lo = r_r != 16'd0;
  assign r_hi = ({1'b0, r_r} + 17'd1) < {8'd0, rows_eff};
  assign q    = {c_hi & r_hi, c_lo & r_hi, c_hi & r_lo, c_lo & r_lo};
  assign n    = 3'(q[0]) + 3'(q[3]) + {1'b0, q[1], 1'b0} + {1'b0, q[2], 1'b0};

  // height store
  logic [15:0] cols16, rd_addr, rdata, h_eff;

  assign cols16 = {7'd0, cols_eff};

  always_comb begin
    case (cmd.rd_sel)
      NB_C:    rd_addr = addr_r;
      NB_L:    rd_addr = addr_r - 16'd1;
      NB_R:    rd_addr = addr_r + 16'd1;
      NB_U:    rd_addr = addr_r - cols16;
      NB_D:    rd_addr = addr_r + cols16;
      NB_UR:   rd_addr = addr_r - cols16 + 16'd1;
      NB_DL:   rd_addr = addr_r + cols16 - 16'd1;
      default: rd_addr = addr_r;
    endcase
  end

  hgvn_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_wr),
    .waddr(in_addr),
    .wdata(in_sample),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign h_eff = use_reg ? rdata : 16'd0;

  // neighbor sums in raw height units
  logic signed [2:0]  cx, cz;
  logic signed [19:0] hs, term_x, term_z;
  logic signed [20:0] sx_raw, sz_raw;
  logic [15:0]        hc;

  assign cx     = coef_x(cmd.acc_sel, q);
  assign cz     = coef_z(cmd.acc_sel, q);
  assign hs     = $signed({4'd0, h_eff});
  assign term_x = (cx == 3'sd0) ? 20'sd0 : hs * 20'(cx);
  assign term_z = (cz == 3'sd0) ? 20'sd0 : hs * 20'(cz);

  // scaled sums and their magnitudes
  logic signed [29:0] px, pz;
  logic [23:0]        py;
  logic [28:0]        mag_x, mag_z;

  assign mag_x = px[29] ? 29'(-px) : 29'(px);
  assign mag_z = pz[29] ? 29'(-pz) : 29'(pz);

  // shared divider
  logic [DIV_W-1:0]     dividend, quo;
  logic [DIVISOR_W-1:0] divisor, rem;
  logic                 div_busy, div_done;

  always_comb begin
    case (cmd.div_src)
      DIV_SRC_ADDR: begin
        dividend = {16'd0, in_addr};
        divisor  = cols16;
      end
      DIV_SRC_X: begin
        dividend = {3'd0, mag_x};
        divisor  = {13'd0, n};
      end
      DIV_SRC_Y: begin
        dividend = {12'd0, {1'b0, n} + 4'd1, 16'd0};
        divisor  = {13'd0, n};
      end
      default: begin
        dividend = {3'd0, mag_z};
        divisor  = {13'd0, n};
      end
    endcase
  end

  hgvn_div #(
    .W(DIV_W),
    .D(DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  logic signed [31:0] nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      addr_r <= in_addr;
    end
    if (cmd.latch_cr) begin
      c_r <= rem[8:0];
      r_r <= quo[15:0];
    end
    if (cmd.acc_clr) begin
      sx_raw <= '0;
      sz_raw <= '0;
    end else if (cmd.acc_en) begin
      sx_raw <= sx_raw + 21'(term_x);
      sz_raw <= sz_raw + 21'(term_z);
      if (cmd.acc_sel == NB_C) begin
        hc <= h_eff;
      end
    end
    if (cmd.mul_en) begin
      px <= 30'($signed({1'b0, scale_reg})) * 30'(sx_raw);
      pz <= 30'($signed({1'b0, scale_reg})) * 30'(sz_raw);
      py <= scale_reg * hc;
    end
    if (cmd.flat_norm) begin
      nx_r <= '0;
      ny_r <= $signed(ONE_Q16);
      nz_r <= '0;
    end
    if (cmd.load_x) begin
      nx_r <= px[29] ? $signed(32'd0 - quo) : $signed(quo);
    end
    if (cmd.load_y) begin
      ny_r <= $signed(quo);
    end
    if (cmd.load_z) begin
      nz_r <= pz[29] ? $signed(32'd0 - quo) : $signed(quo);
    end
    if (cmd.out_load) begin
      pos_y  <= $signed({{5{base_reg[10]}}, base_reg, 16'd0} + {8'd0, py});
      norm_x <= nx_r;
      norm_y <= ny_r;
      norm_z <= nz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.div_busy    = div_busy;
  assign stat.div_done    = div_done;
  assign stat.out_of_grid = r_r >= {7'd0, rows_eff};
  assign stat.n_zero      = n == 3'd0;
  assign stat.out_busy    = out_valid & ~out_ready;

endmodule

// File: rtl/heightmap_grid_vertex_normals.sv
// Top level of the height-map vertex unit: world height and averaged normal per vertex.
// Store: one transfer per cycle while the sequencer idles, no result; the sample is
//   in memory the next cycle. Read: address divide, grid check, neighbor fetch,
//   scale, prep, three normal divides on the shared divider (skipped for n = 0), load.
// One read at a time: input waits until the result is loaded or the read is off grid.
// Reset (rst, synchronous) restores config and idles the sequencer; memory is not cleared.
`timescale 1ns / 1ps
module heightmap_grid_vertex_normals #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  hgvn_in_if.sink                         in,
  hgvn_out_if.source                      out,
  input  logic                            cfg_we,
  input  logic [hgvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgvn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hgvn_pkg::*;

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: takes the request transfer, steps the read through its phases
  hgvn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in.valid),
    .in_cmd  (in.cmd),
    .in_ready(in.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: config, height memory, neighbor sums, divider, result register
  hgvn_dp #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_addr  (in.vertex_addr),
    .in_sample(in.height_sample),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(out.ready),
    .out_valid(out.valid),
    .pos_y    (out.pos_y),
    .norm_x   (out.norm_x),
    .norm_y   (out.norm_y),
    .norm_z   (out.norm_z)
  );

endmodule

// File: bench/tb.sv
// Self-checking bench for the height-map vertex unit: stores, vertex reads, config sweeps.
`timescale 1ns / 1ps
module tb;
  import hgvn_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [31:0] pos_y;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
  } vertex_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hgvn_in_if  req_ch ();
  hgvn_out_if res_ch ();

  heightmap_grid_vertex_normals dut (
    .clk      (clk),
    .rst      (rst),
    .in       (req_ch),
    .out      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the block's state and registers.
  logic [15:0] shadow_heights [0:65535];
  bit          written [0:65535];
  logic [8:0]  m_cols;
  logic [8:0]  m_rows;
  logic [7:0]  m_scale;
  logic signed [10:0] m_base;
  logic        m_use;

  vertex_res_t pending_vertices[$];
  int  errors = 0;
  int  reads_checked;
  int  stores_sent;
  int  reads_sent;
  int  configs_done;
  int  cycle_count = 0;
  bit  quiet;          // no sender gaps while set
  int  stall_reqs;
  int  stall_seen;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Global watchdog: count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_seen <= 0;
    end else if (stall_seen != stall_reqs) begin
      stall_seen <= stall_reqs;
      stall_left <= 600;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (quiet) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= (gap_len() == 0);
    end
  end

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("tb: mismatch on %s: got %h, expected %h", field, got, want);
  endtask

  // Compare each result transfer against the oldest prediction.
  always @(posedge clk) begin
    vertex_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("tb: result with nothing expected, pos_y %h", res_ch.pos_y);
      end else begin
        want = pending_vertices.pop_front();
        reads_checked++;
        if (res_ch.pos_y !== want.pos_y) report("pos_y", res_ch.pos_y, want.pos_y);
        if (res_ch.norm_x !== want.norm_x) report("norm_x", res_ch.norm_x, want.norm_x);
        if (res_ch.norm_y !== want.norm_y) report("norm_y", res_ch.norm_y, want.norm_y);
        if (res_ch.norm_z !== want.norm_z) report("norm_z", res_ch.norm_z, want.norm_z);
      end
    end
  end

  function automatic int eff_cols();
    if (m_cols == 0) return 1;
    if (m_cols > 256) return 256;
    return int'(m_cols);
  endfunction

  function automatic int eff_rows();
    if (m_rows == 0) return 1;
    if (m_rows > 256) return 256;
    return int'(m_rows);
  endfunction

  function automatic longint height_at(int c, int r, int cols);
    longint y;
    y = longint'(m_base) * 65536;
    if (m_use) y += longint'(m_scale) * longint'(shadow_heights[(r * cols + c) & 16'hFFFF]);
    return y;
  endfunction

  // Height and averaged normal of one vertex; returns 0 for a read off the grid.
  function automatic bit predict_vertex(logic [15:0] addr, output vertex_res_t res);
    int cols, rows, c, r, i, j;
    longint sx, sy, sz, n, h00, h10, h01, h11;
    cols = eff_cols();
    rows = eff_rows();
    res = '0;
    if (int'(addr) / cols >= rows) return 0;
    c = int'(addr) % cols;
    r = int'(addr) / cols;
    sx = 0; sy = 65536; sz = 0; n = 0;
    for (int dj = 0; dj < 2; dj++) begin
      for (int di = 0; di < 2; di++) begin
        i = c - 1 + di;
        j = r - 1 + dj;
        if (i < 0 || j < 0 || i + 1 >= cols || j + 1 >= rows) continue;
        h00 = height_at(i, j, cols);
        h10 = height_at(i + 1, j, cols);
        h01 = height_at(i, j + 1, cols);
        h11 = height_at(i + 1, j + 1, cols);
        // lower-left triangle of the quad
        if ((c == i && r == j) || (c == i && r == j + 1) || (c == i + 1 && r == j)) begin
          sx -= h10 - h00; sy += 65536; sz -= h01 - h00; n++;
        end
        // upper-right triangle
        if ((c == i + 1 && r == j) || (c == i && r == j + 1) ||
            (c == i + 1 && r == j + 1)) begin
          sx += h01 - h11; sy += 65536; sz += h10 - h11; n++;
        end
      end
    end
    res.pos_y = 32'(height_at(c, r, cols));
    if (n == 0) begin
      res.norm_y = 32'sh0001_0000;
    end else begin
      res.norm_x = 32'(sx / n);
      res.norm_y = 32'(sy / n);
      res.norm_z = 32'(sz / n);
    end
    return 1;
  endfunction

  // Offer one item, hold until transferred, then advance the shadow model.
  task automatic send_item(logic c, logic [15:0] addr, logic [15:0] sample);
    int g;
    vertex_res_t res;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.vertex_addr <= addr;
    req_ch.height_sample <= sample;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (c == CMD_STORE) begin
      shadow_heights[addr] = sample;
      written[addr] = 1'b1;
      stores_sent++;
    end else begin
      reads_sent++;
      if (predict_vertex(addr, res)) pending_vertices = {pending_vertices, res};
    end
  endtask

  // Read a vertex, first storing any neighbor that holds no sample yet.
  task automatic read_vertex(logic [15:0] addr);
    int cols, rows, c, r, a;
    cols = eff_cols();
    rows = eff_rows();
    if (int'(addr) / cols < rows) begin
      c = int'(addr) % cols;
      r = int'(addr) / cols;
      for (int y = r - 1; y <= r + 1; y++)
        for (int x = c - 1; x <= c + 1; x++) begin
          if (x < 0 || y < 0 || x >= cols || y >= rows) continue;
          a = (y * cols + x) & 16'hFFFF;
          if (!written[a]) send_item(CMD_STORE, 16'(a), 16'($urandom_range(0, 65535)));
        end
    end
    send_item(CMD_READ, addr, 16'($urandom_range(0, 65535)));
  endtask

  // Drop valid and wait until every prediction has been matched.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int cols, int rows, int scale, int base, bit use_h);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    drain();
    idx = '{CFG_GRID_COLS, CFG_GRID_ROWS, CFG_HEIGHT_SCALE, CFG_BASE_HEIGHT, CFG_USE_HEIGHTS};
    val = '{CFG_DATA_W'(cols[8:0]), CFG_DATA_W'(rows[8:0]), CFG_DATA_W'(scale[7:0]),
            base[10:0], CFG_DATA_W'(use_h)};
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_cols = cols[8:0];
    m_rows = rows[8:0];
    m_scale = scale[7:0];
    m_base = base[10:0];
    m_use = use_h;
    configs_done++;
  endtask

  // Random mix on the current grid: mostly in-grid reads and stores, some noise.
  task automatic random_traffic(int count);
    int cells, p;
    cells = eff_cols() * eff_rows();
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (k % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (p < 35) send_item(CMD_STORE, 16'($urandom_range(0, cells - 1)), 16'($urandom));
      else if (p < 40) send_item(CMD_STORE, 16'($urandom_range(0, 65535)), 16'($urandom));
      else if (p < 92 || cells >= 65536) read_vertex(16'($urandom_range(0, cells - 1)));
      else send_item(CMD_READ, 16'($urandom_range(cells, 65535)), 16'($urandom));
    end
    quiet = 1'b0;
  endtask

  // Defaults after reset: full 256x256 grid, extreme samples, corners and edges.
  task automatic test_reset_defaults();
    send_item(CMD_STORE, 16'd0, 16'hFFFF);
    send_item(CMD_STORE, 16'd1, 16'h0000);
    send_item(CMD_STORE, 16'd256, 16'h0000);
    send_item(CMD_STORE, 16'd257, 16'hFFFF);
    read_vertex(16'd0);
    read_vertex(16'd257);
    read_vertex(16'd65535);
    read_vertex(16'd255);
    read_vertex(16'd65280);
    read_vertex(16'h5AA5);
  endtask

  // Small grids, clamped sizes, single row/column, flat mode, register extremes.
  task automatic test_grid_shapes();
    set_config(4, 3, 255, 1023, 1'b1);
    read_vertex(16'd5);
    read_vertex(16'd11);
    send_item(CMD_READ, 16'd12, 16'd0);    // first row past the grid: ignored
    set_config(1, 5, 17, -1024, 1'b1);      // single column
    read_vertex(16'd2);
    set_config(6, 1, 200, 5, 1'b1);         // single row
    read_vertex(16'd3);
    send_item(CMD_READ, 16'd6, 16'd0);
    set_config(0, 0, 0, 0, 1'b1);           // sizes clamp up to one
    read_vertex(16'd0);
    send_item(CMD_READ, 16'd1, 16'd0);
    set_config(300, 2, 1, -1, 1'b1);        // columns clamp down to the maximum
    read_vertex(16'd256);
    read_vertex(16'd300);
    set_config(5, 4, 255, -1024, 1'b0);     // flat grid
    read_vertex(16'd6);
    read_vertex(16'd0);
    read_vertex(16'd19);
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    set_config(8, 8, 123, -300, 1'b1);
    for (int k = 0; k < 64; k++) send_item(CMD_STORE, 16'(k), 16'($urandom));
    stall_reqs++;
    quiet = 1'b1;
    for (int k = 0; k < 6; k++) send_item(CMD_READ, 16'($urandom_range(0, 63)), 16'd0);
    quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    int cols, rows;
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 5))
        0: begin cols = 256; rows = 256; end
        1: begin cols = $urandom_range(0, 1); rows = $urandom_range(1, 30); end
        2: begin cols = $urandom_range(257, 511); rows = $urandom_range(1, 2); end
        default: begin cols = $urandom_range(2, 12); rows = $urandom_range(2, 12); end
      endcase
      set_config(cols, rows, $urandom_range(0, 255), $urandom_range(0, 2047),
                 $urandom_range(0, 3) != 0);
      random_traffic(ph == 0 ? 40 : 60);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_STORE;
    req_ch.vertex_addr = '0;
    req_ch.height_sample = '0;
    quiet = 1'b0;
    stall_reqs = 0;
    m_cols = 9'd256; m_rows = 9'd256; m_scale = 8'd80; m_base = -11'sd80; m_use = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_grid_shapes();
    test_backpressure();
    test_random_phases();
    drain();

    $display("tb: %0d stores and %0d reads sent, %0d results checked", stores_sent,
             reads_sent, reads_checked);
    $display("tb: %0d register settings incl. clamped sizes, flat mode, backpressure",
             configs_done);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/hgvn_pkg.sv
rtl/hgvn_if.sv
rtl/hgvn_ram.sv
rtl/hgvn_div.sv
rtl/hgvn_ctrl.sv
rtl/hgvn_dp.sv
rtl/heightmap_grid_vertex_normals.sv
bench/tb.sv
